// File: sv/assert_macros.svh
// Assertion macros shared by the Kalman filter RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KCV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kcv assertion failed");

// Condition must never be true outside reset.
`define KCV_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kcv forbidden condition seen");

`endif

// File: sv/kcv_pkg.sv
// Shared constants, types and saturating helpers of the 3D Kalman filter.
// No dependencies; used by every module of the block.
package kcv_pkg;

    localparam int AXES = 3;

    localparam logic signed [63:0] LIM       = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] VAR_MAX   = 64'sh0000_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] COV_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] COV_MIN   = 64'shFFFF_8000_0000_0000;
    localparam logic signed [63:0] S32_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN   = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [63:0] GAIN_ONE  = 64'sh0000_0001_0000_0000;

    localparam logic [20:0] STEP_TIME_RST = 21'd10486;
    localparam logic [40:0] POS_NOISE_RST = 41'd21475;
    localparam logic [40:0] VEL_NOISE_RST = 41'd21475;
    localparam logic [40:0] MEAS_NOISE_RST = 41'd42949673;
    localparam logic [47:0] VAR_RST       = 48'd429496729600;

    localparam logic [2:0] CFG_STEP_TIME  = 3'd0;
    localparam logic [2:0] CFG_POS_NOISE  = 3'd1;
    localparam logic [2:0] CFG_VEL_NOISE  = 3'd2;
    localparam logic [2:0] CFG_MEAS_NOISE = 3'd3;
    localparam logic [2:0] CFG_INIT_VAR   = 3'd4;

    typedef struct packed {
        logic start_pre;
        logic start_upd;
    } t_seq_ctl;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({LIM[63], LIM})) begin
            return LIM;
        end else if (s < -$signed({LIM[63], LIM})) begin
            return -LIM;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_var(input logic signed [63:0] x);
        if (x < 0) begin
            return 64'sd0;
        end else if (x > VAR_MAX) begin
            return VAR_MAX;
        end
        return x;
    endfunction

    function automatic logic signed [63:0] clamp_cov(input logic signed [63:0] x);
        if (x < COV_MIN) begin
            return COV_MIN;
        end else if (x > COV_MAX) begin
            return COV_MAX;
        end
        return x;
    endfunction

    function automatic logic signed [31:0] clamp_s32(input logic signed [63:0] x);
        if (x < S32_MIN) begin
            return S32_MIN[31:0];
        end else if (x > S32_MAX) begin
            return S32_MAX[31:0];
        end
        return x[31:0];
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

endpackage

// File: sv/kcv_if.sv
// Handshake channels of the Kalman filter: measurement, estimate, configuration.
// Depends on nothing but the clock domain of the block.
interface kcv_meas_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    modport source (output valid, meas_x, meas_y, meas_z, input ready);
    modport sink (input valid, meas_x, meas_y, meas_z, output ready);
endinterface

interface kcv_est_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_pos_x;
    logic signed [31:0] est_pos_y;
    logic signed [31:0] est_pos_z;
    logic signed [31:0] est_vel_x;
    logic signed [31:0] est_vel_y;
    logic signed [31:0] est_vel_z;
    modport source (output valid, est_pos_x, est_pos_y, est_pos_z,
                    est_vel_x, est_vel_y, est_vel_z, input ready);
    modport sink (input valid, est_pos_x, est_pos_y, est_pos_z,
                  est_vel_x, est_vel_y, est_vel_z, output ready);
endinterface

interface kcv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/constant_velocity_kalman_3d.sv
// Channel     | Dir | Payload
// i_meas      | in  | meas_x, meas_y, meas_z (signed Q12.20)
// o_est       | out | est_pos_x/y/z, est_vel_x/y/z (signed Q12.20)
// i_cfg       | in  | index (3 bit), data (48 bit), always ready
//
// For each measurement the covariance sequencer runs 13 products through its
// shared multiplier, and the two gain dividers each produce 80 quotient bits,
// one quotient bit per cycle.
// Reset is synchronous; it restores control, configuration and filter state to their defaults.
// A finished estimate waits in the output register; the next measurement is
// taken meanwhile, and only the final load waits for that register to empty.
`include "assert_macros.svh"
module constant_velocity_kalman_3d (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kcv_meas_if.sink      i_meas,
    kcv_est_if.source     o_est,
    kcv_cfg_if.sink       i_cfg
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam int AXES = kcv_pkg::AXES;

    logic [2:0]         r_state;
    kcv_pkg::t_seq_ctl  r_ctl;
    logic               r_div_go;
    logic               r_cov_ok;
    logic               r_lane_ok;
    logic               r_ov;
    logic [20:0]        r_step_time;
    logic [40:0]        r_pos_noise;
    logic [40:0]        r_vel_noise;
    logic [40:0]        r_meas_noise;
    logic signed [31:0] r_meas [AXES];
    logic signed [31:0] r_out_pos [AXES];
    logic signed [31:0] r_out_vel [AXES];

    logic               cov_done;
    logic signed [63:0] cov_a;
    logic signed [63:0] cov_b;
    logic signed [63:0] den;
    logic               div1_done;
    logic               div2_done;
    logic signed [63:0] k1;
    logic signed [63:0] k2;
    logic [AXES-1:0]    lane_done;
    logic signed [31:0] lane_pos [AXES];
    logic signed [31:0] lane_vel [AXES];
    logic               in_acc;
    logic               load_out;
    logic               cov_fin;
    logic               lane_fin;

    assign i_meas.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_acc       = i_meas.valid && i_meas.ready;
    assign den          = cov_a + $signed({23'd0, r_meas_noise});
    assign cov_fin      = r_cov_ok || cov_done;
    assign lane_fin     = r_lane_ok || (&lane_done);
    assign load_out     = (r_state == S_OUT) && (!r_ov || o_est.ready);

    kcv_cov u_cov (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_ctl),
        .i_step_time  (r_step_time),
        .i_pos_noise  (r_pos_noise),
        .i_vel_noise  (r_vel_noise),
        .i_meas_noise (r_meas_noise),
        .i_k1         (k1),
        .i_k2         (k2),
        .o_done       (cov_done),
        .o_a          (cov_a),
        .o_b          (cov_b)
    );

    kcv_div u_div_k1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (cov_a),
        .i_den   (den),
        .o_done  (div1_done),
        .o_gain  (k1)
    );

    kcv_div u_div_k2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (cov_b),
        .i_den   (den),
        .o_done  (div2_done),
        .o_gain  (k2)
    );

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        kcv_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (r_ctl),
            .i_meas      (r_meas[g]),
            .i_step_time (r_step_time),
            .i_k1        (k1),
            .i_k2        (k2),
            .o_done      (lane_done[g]),
            .o_pos       (lane_pos[g]),
            .o_vel       (lane_vel[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time  <= kcv_pkg::STEP_TIME_RST;
            r_pos_noise  <= kcv_pkg::POS_NOISE_RST;
            r_vel_noise  <= kcv_pkg::VEL_NOISE_RST;
            r_meas_noise <= kcv_pkg::MEAS_NOISE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            // The initial variance only matters at reset, which restores its
            // default, so a write to it has no visible effect.
            case (i_cfg.index)
                kcv_pkg::CFG_STEP_TIME:  r_step_time  <= i_cfg.data[20:0];
                kcv_pkg::CFG_POS_NOISE:  r_pos_noise  <= i_cfg.data[40:0];
                kcv_pkg::CFG_VEL_NOISE:  r_vel_noise  <= i_cfg.data[40:0];
                kcv_pkg::CFG_MEAS_NOISE: r_meas_noise <= i_cfg.data[40:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ctl     <= '0;
            r_div_go  <= 1'b0;
            r_cov_ok  <= 1'b0;
            r_lane_ok <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_ctl    <= '0;
            r_div_go <= 1'b0;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_est.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state       <= S_PRED;
                        r_ctl.start_pre <= 1'b1;
                    end
                end
                S_PRED, S_UPD: begin
                    if (cov_fin && lane_fin) begin
                        r_cov_ok  <= 1'b0;
                        r_lane_ok <= 1'b0;
                        if (r_state == S_PRED) begin
                            r_state  <= S_DIV;
                            r_div_go <= 1'b1;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_cov_ok  <= cov_fin;
                        r_lane_ok <= lane_fin;
                    end
                end
                S_DIV: begin
                    if (div1_done) begin
                        r_state         <= S_UPD;
                        r_ctl.start_upd <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_meas[0] <= i_meas.meas_x;
            r_meas[1] <= i_meas.meas_y;
            r_meas[2] <= i_meas.meas_z;
        end
        if (load_out) begin
            r_out_pos <= lane_pos;
            r_out_vel <= lane_vel;
        end
    end

    assign o_est.valid     = r_ov;
    assign o_est.est_pos_x = r_out_pos[0];
    assign o_est.est_pos_y = r_out_pos[1];
    assign o_est.est_pos_z = r_out_pos[2];
    assign o_est.est_vel_x = r_out_vel[0];
    assign o_est.est_vel_y = r_out_vel[1];
    assign o_est.est_vel_z = r_out_vel[2];

    `KCV_ASSERT(a_lane_done_in_phase, i_clk, i_rst_n,
        (|lane_done) |-> (r_state == S_PRED || r_state == S_UPD))
    `KCV_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_state) == S_OUT)
    `KCV_NEVER(a_div_pair_skew, i_clk, i_rst_n, div1_done != div2_done)

endmodule

// File: sv/kcv_mul.sv
// Multi-cycle rounding multiplier: 64x64 magnitude product built from four
// 32x32 partial products, then rounded, shifted and held to +-2^61. Uses kcv_pkg.
`include "assert_macros.svh"
module kcv_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic               i_sh32,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    localparam logic [63:0] LIM_U = 64'(kcv_pkg::LIM);

    logic               r_busy;
    logic [2:0]         r_cnt;
    logic [63:0]        r_ux;
    logic [63:0]        r_uy;
    logic               r_neg;
    logic               r_sh32;
    logic [127:0]       r_acc;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [6:0]   pp_shamt;
    logic [127:0] pp_shifted;
    logic [127:0] rounded;
    logic [127:0] quot;
    logic [63:0]  umag;

    always_comb begin
        a_half     = r_cnt[0] ? r_ux[63:32] : r_ux[31:0];
        b_half     = r_cnt[1] ? r_uy[63:32] : r_uy[31:0];
        pp         = a_half * b_half;
        pp_shamt   = {r_cnt[0] & r_cnt[1], r_cnt[0] ^ r_cnt[1], 5'd0};
        pp_shifted = {64'd0, pp} << pp_shamt;
        rounded    = r_acc + (r_sh32 ? (128'd1 << 31) : (128'd1 << 19));
        quot       = r_sh32 ? (rounded >> 32) : (rounded >> 20);
        if (quot > {64'd0, LIM_U}) begin
            umag = LIM_U;
        end else begin
            umag = quot[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ux   <= kcv_pkg::mag(i_x);
            r_uy   <= kcv_pkg::mag(i_y);
            r_neg  <= i_x[63] ^ i_y[63];
            r_sh32 <= i_sh32;
            r_acc  <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                r_res <= r_neg ? -$signed(umag) : $signed(umag);
            end else begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `KCV_ASSERT(a_mul_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))

endmodule

// File: sv/kcv_div.sv
// Restoring divider for the Kalman gain: num / den with 32 fractional bits,
// truncated toward zero, one quotient bit per cycle. Uses kcv_pkg.
`include "assert_macros.svh"
module kcv_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_gain
);
    localparam int QBITS = 80;

    logic               r_busy;
    logic [6:0]         r_cnt;
    logic [79:0]        r_dvd;
    logic [48:0]        r_rem;
    logic [79:0]        r_q;
    logic [48:0]        r_d;
    logic               r_neg;
    logic               r_done;
    logic signed [63:0] r_gain;

    logic [63:0] num_mag;
    logic [49:0] rem_sh;
    logic        ge;
    logic [49:0] rem_sub;
    logic [79:0] n_q;
    logic [63:0] kmag;

    always_comb begin
        num_mag = kcv_pkg::mag(i_num);
        rem_sh  = {r_rem, r_dvd[79]};
        ge      = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
        n_q     = {r_q[78:0], ge};
        // The quotient saturates once its integer part reaches 2^29.
        if (n_q[79:61] != 19'd0) begin
            kmag = 64'(kcv_pkg::LIM);
        end else begin
            kmag = {3'd0, n_q[60:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 7'd0;
                if (i_den <= 0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(QBITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {num_mag[47:0], 32'd0};
            r_rem  <= 49'd0;
            r_q    <= 80'd0;
            r_d    <= i_den[48:0];
            r_neg  <= i_num[63];
            r_gain <= 64'sd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[78:0], 1'b0};
            r_rem <= ge ? rem_sub[48:0] : rem_sh[48:0];
            r_q   <= n_q;
            if (r_cnt == 7'(QBITS - 1)) begin
                r_gain <= r_neg ? -$signed(kmag) : $signed(kmag);
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_gain;

    `KCV_ASSERT(a_gain_bounded, i_clk, i_rst_n,
        r_done |-> (r_gain <= kcv_pkg::LIM && r_gain >= -kcv_pkg::LIM))

endmodule

// File: sv/kcv_lane.sv
// One axis of the filter: position and velocity state, prediction and
// correction through its own rounding multiplier. Uses kcv_pkg and kcv_mul.
module kcv_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kcv_pkg::t_seq_ctl   i_ctl,
    input  logic signed [31:0]  i_meas,
    input  logic [20:0]         i_step_time,
    input  logic signed [63:0]  i_k1,
    input  logic signed [63:0]  i_k2,
    output logic                o_done,
    output logic signed [31:0]  o_pos,
    output logic signed [31:0]  o_vel
);
    localparam logic [1:0] LP_IDLE = 2'd0;
    localparam logic [1:0] LP_PRED = 2'd1;
    localparam logic [1:0] LP_K1   = 2'd2;
    localparam logic [1:0] LP_K2   = 2'd3;

    logic [1:0]         r_ph;
    logic               r_go;
    logic               r_done;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_p;
    logic signed [32:0] r_inn;
    logic signed [31:0] r_newpos;

    logic               mul_done;
    logic signed [63:0] mul_res;
    logic signed [63:0] mul_x;
    logic signed [63:0] mul_y;
    logic               mul_sh32;
    logic signed [31:0] pred_p;

    always_comb begin
        case (r_ph)
            LP_PRED: begin
                mul_x    = 64'(r_vel);
                mul_y    = $signed({43'd0, i_step_time});
                mul_sh32 = 1'b0;
            end
            LP_K1: begin
                mul_x    = 64'(r_inn);
                mul_y    = i_k1;
                mul_sh32 = 1'b1;
            end
            LP_K2: begin
                mul_x    = 64'(r_inn);
                mul_y    = i_k2;
                mul_sh32 = 1'b1;
            end
            default: begin
                mul_x    = 64'sd0;
                mul_y    = 64'sd0;
                mul_sh32 = 1'b0;
            end
        endcase
        pred_p = kcv_pkg::clamp_s32(64'(r_pos) + mul_res);
    end

    kcv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_sh32  (mul_sh32),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= LP_IDLE;
            r_go   <= 1'b0;
            r_done <= 1'b0;
            r_pos  <= 32'sd0;
            r_vel  <= 32'sd0;
        end else begin
            r_go   <= 1'b0;
            r_done <= 1'b0;
            if (i_ctl.start_pre) begin
                r_ph <= LP_PRED;
                r_go <= 1'b1;
            end else if (i_ctl.start_upd) begin
                r_ph <= LP_K1;
                r_go <= 1'b1;
            end else if (mul_done) begin
                case (r_ph)
                    LP_PRED: begin
                        r_ph   <= LP_IDLE;
                        r_done <= 1'b1;
                    end
                    LP_K1: begin
                        r_ph <= LP_K2;
                        r_go <= 1'b1;
                    end
                    LP_K2: begin
                        r_vel  <= kcv_pkg::clamp_s32(64'(r_vel) + mul_res);
                        r_pos  <= r_newpos;
                        r_ph   <= LP_IDLE;
                        r_done <= 1'b1;
                    end
                    default: begin
                        r_ph <= LP_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_done && r_ph == LP_PRED) begin
            r_p   <= pred_p;
            r_inn <= 33'(i_meas) - 33'(pred_p);
        end
        if (mul_done && r_ph == LP_K1) begin
            r_newpos <= kcv_pkg::clamp_s32(64'(r_p) + mul_res);
        end
    end

    assign o_done = r_done;
    assign o_pos  = r_pos;
    assign o_vel  = r_vel;

endmodule

// File: sv/kcv_cov.sv
// Shared 2x2 covariance: prediction before the gain and Joseph-form update
// after it, sequenced over one rounding multiplier. Uses kcv_pkg and kcv_mul.
module kcv_cov (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kcv_pkg::t_seq_ctl  i_ctl,
    input  logic [20:0]        i_step_time,
    input  logic [40:0]        i_pos_noise,
    input  logic [40:0]        i_vel_noise,
    input  logic [40:0]        i_meas_noise,
    input  logic signed [63:0] i_k1,
    input  logic signed [63:0] i_k2,
    output logic               o_done,
    output logic signed [63:0] o_a,
    output logic signed [63:0] o_b
);
    localparam logic [3:0] ST_VV_T    = 4'd0;
    localparam logic [3:0] ST_CPV_T   = 4'd1;
    localparam logic [3:0] ST_B_T     = 4'd2;
    localparam logic [3:0] ST_RK1     = 4'd3;
    localparam logic [3:0] ST_A_OMK   = 4'd4;
    localparam logic [3:0] ST_T1_OMK  = 4'd5;
    localparam logic [3:0] ST_RK1_K1  = 4'd6;
    localparam logic [3:0] ST_A_K2    = 4'd7;
    localparam logic [3:0] ST_X_OMK   = 4'd8;
    localparam logic [3:0] ST_RK1_K2  = 4'd9;
    localparam logic [3:0] ST_B_K2    = 4'd10;
    localparam logic [3:0] ST_S_K2    = 4'd11;
    localparam logic [3:0] ST_T_K2    = 4'd12;

    logic [3:0]         r_step;
    logic               r_run;
    logic               r_pend;
    logic               r_done;
    logic [47:0]        r_vp;
    logic signed [47:0] r_cpv;
    logic [47:0]        r_vv;
    logic signed [63:0] r_a;
    logic signed [63:0] r_b;
    logic signed [63:0] r_c;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_t1;
    logic signed [63:0] r_x;
    logic signed [63:0] r_rk1;
    logic signed [63:0] r_n11;
    logic signed [63:0] r_n12;

    logic               mul_start;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic signed [63:0] mul_x;
    logic signed [63:0] mul_y;
    logic               mul_sh32;
    logic signed [63:0] vp_e;
    logic signed [63:0] cpv_e;
    logic signed [63:0] vv_e;
    logic signed [63:0] t_e;
    logic signed [63:0] r_e;
    logic signed [63:0] omk;
    logic               last;

    always_comb begin
        vp_e  = $signed({16'd0, r_vp});
        cpv_e = 64'(r_cpv);
        vv_e  = $signed({16'd0, r_vv});
        t_e   = $signed({43'd0, i_step_time});
        r_e   = $signed({23'd0, i_meas_noise});
        omk   = kcv_pkg::GAIN_ONE - i_k1;
        mul_sh32 = 1'b1;
        case (r_step)
            ST_VV_T: begin
                mul_x = vv_e;    mul_y = t_e;  mul_sh32 = 1'b0;
            end
            ST_CPV_T: begin
                mul_x = cpv_e;   mul_y = t_e;  mul_sh32 = 1'b0;
            end
            ST_B_T: begin
                mul_x = r_b;     mul_y = t_e;  mul_sh32 = 1'b0;
            end
            ST_RK1:    begin mul_x = r_e;   mul_y = i_k1; end
            ST_A_OMK:  begin mul_x = r_a;   mul_y = omk;  end
            ST_T1_OMK: begin mul_x = r_t1;  mul_y = omk;  end
            ST_RK1_K1: begin mul_x = r_rk1; mul_y = i_k1; end
            ST_A_K2:   begin mul_x = r_a;   mul_y = i_k2; end
            ST_X_OMK:  begin mul_x = r_x;   mul_y = omk;  end
            ST_RK1_K2: begin mul_x = r_rk1; mul_y = i_k2; end
            ST_B_K2:   begin mul_x = r_b;   mul_y = i_k2; end
            ST_S_K2:   begin mul_x = kcv_pkg::sadd(r_a, r_e); mul_y = i_k2; end
            ST_T_K2:   begin mul_x = r_t1;  mul_y = i_k2; end
            default:   begin mul_x = 64'sd0; mul_y = 64'sd0; end
        endcase
        mul_start = r_run && !r_pend;
        last      = (r_step == ST_B_T) || (r_step == ST_T_K2);
    end

    kcv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_sh32  (mul_sh32),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_VV_T;
            r_run  <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
            r_vp   <= kcv_pkg::VAR_RST;
            r_cpv  <= 48'sd0;
            r_vv   <= kcv_pkg::VAR_RST;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start_pre) begin
                r_step <= ST_VV_T;
                r_run  <= 1'b1;
            end else if (i_ctl.start_upd) begin
                r_step <= ST_RK1;
                r_run  <= 1'b1;
            end else if (mul_start) begin
                r_pend <= 1'b1;
            end else if (mul_done) begin
                r_pend <= 1'b0;
                if (last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 4'd1;
                end
                if (r_step == ST_T_K2) begin
                    r_vp  <= r_n11[47:0];
                    r_cpv <= r_n12[47:0];
                    r_vv  <= 48'(kcv_pkg::clamp_var(kcv_pkg::sadd(r_x, mul_res)));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_done) begin
            case (r_step)
                ST_VV_T:  r_b   <= kcv_pkg::sadd(cpv_e, mul_res);
                ST_CPV_T: r_acc <= kcv_pkg::sadd(vp_e, mul_res);
                ST_B_T: begin
                    r_a <= kcv_pkg::clamp_var(kcv_pkg::sadd(kcv_pkg::sadd(r_acc, mul_res),
                                                            $signed({23'd0, i_pos_noise})));
                    r_b <= kcv_pkg::clamp_cov(r_b);
                    r_c <= kcv_pkg::clamp_var(kcv_pkg::sadd(vv_e,
                                                            $signed({23'd0, i_vel_noise})));
                end
                ST_RK1:    r_rk1 <= mul_res;
                ST_A_OMK:  r_t1  <= mul_res;
                ST_T1_OMK: r_acc <= mul_res;
                ST_RK1_K1: r_n11 <= kcv_pkg::clamp_var(kcv_pkg::sadd(r_acc, mul_res));
                ST_A_K2:   r_x   <= kcv_pkg::sadd(r_b, -mul_res);
                ST_X_OMK:  r_acc <= mul_res;
                ST_RK1_K2: r_n12 <= kcv_pkg::clamp_cov(kcv_pkg::sadd(r_acc, mul_res));
                ST_B_K2:   r_x   <= kcv_pkg::sadd(r_c, -kcv_pkg::sadd(mul_res, mul_res));
                ST_S_K2:   r_t1  <= mul_res;
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_a    = r_a;
    assign o_b    = r_b;

endmodule
